/* rtl/core/mbl_pkg.sv */
// Shared constants for the multichannel biquad low-pass filter.
// Field widths, coefficient reset values, register indexes and a width helper.
// No dependencies.
package mbl_pkg;

   localparam int NUM_CHANNELS_DEF   = 6;
   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int COEF_FRAC_BITS_DEF = 28;
   localparam int HIST_FRAC_BITS_DEF = 24;

   localparam int CHAN_BITS      = 3;
   localparam int COEF_BITS      = 32;
   localparam int HIST_BITS      = 42;
   localparam int FILT_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [FILT_BITS-1:0] FILT_MAX = 16'hFFFF;

   // Coefficient register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2 = 3'd4;

   // Reset coefficients, signed Q3.28
   localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 32'sd40265;
   localparam logic signed [COEF_BITS-1:0] COEF_B1_RESET = 32'sd80531;
   localparam logic signed [COEF_BITS-1:0] COEF_B2_RESET = 32'sd40265;
   localparam logic signed [COEF_BITS-1:0] COEF_A1_RESET = -32'sd527341453;
   localparam logic signed [COEF_BITS-1:0] COEF_A2_RESET = 32'sd259067059;

   // Address width for a memory of the given depth, at least one bit
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

/* rtl/core/mbl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on mbl_pkg for the address width helper.
module mbl_ram import mbl_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [addr_bits(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic                          rd_en,
   input  logic [addr_bits(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/multichannel_biquad_lowpass.sv */
// Six-channel direct form I biquad low-pass filter, fixed point, with per-channel
// history held in one RAM (mbl_ram). Depends on mbl_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata: chan, sample
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: out_chan, filtered
//   csr      in         csr_valid/csr_ready    csr_index, csr_data (coefficients)
//
// One item per cycle while rsp is not stalled and the item's channel is not held in
// the pipe; each item passes stages one to four, then the rsp output register. An
// item for a channel that is still in the four-stage pipe waits until that channel's
// history is written back to the history RAM.
// Synchronous reset clears control state and marks all history as zero at once.
// A result stalled on rsp lets empty stages close up; once the last stage also holds
// an item, the whole pipe and the input stop.
module multichannel_biquad_lowpass import mbl_pkg::*; #(
   parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int HIST_FRAC_BITS = HIST_FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // chan [2:0], sample [3 +: SAMPLE_BITS], zero fill
   input  logic [((CHAN_BITS+SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // out_chan [2:0], filtered [18:3], zero fill
   output logic [((CHAN_BITS+FILT_BITS+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]                      csr_index,
   input  logic [COEF_BITS-1:0]                           csr_data
);

   localparam int RSP_W   = ((CHAN_BITS+FILT_BITS+7)/8)*8;
   localparam int AW      = addr_bits(NUM_CHANNELS);
   localparam int SB      = SAMPLE_BITS;
   localparam int HW      = HIST_BITS;
   localparam int LO_BITS = HW / 2;
   localparam int HI_BITS = HW - LO_BITS;
   localparam int PFF_W   = COEF_BITS + SB + 1;
   localparam int FF_W    = PFF_W + 2;
   localparam int FF_LSH  = (HIST_FRAC_BITS >= COEF_FRAC_BITS) ?
                            HIST_FRAC_BITS - COEF_FRAC_BITS : 0;
   localparam int FF_RSH  = (HIST_FRAC_BITS >= COEF_FRAC_BITS) ?
                            0 : COEF_FRAC_BITS - HIST_FRAC_BITS;
   localparam int FFS_W   = FF_W + FF_LSH;
   localparam int PHI_W   = COEF_BITS + HI_BITS;
   localparam int PLO_W   = COEF_BITS + LO_BITS + 1;
   localparam int FB_W    = COEF_BITS + HW;
   localparam int SUM_W   = ((FFS_W > FB_W) ? FFS_W : FB_W) + 2;

   typedef struct packed {
      logic [SB-1:0] x2;
      logic [SB-1:0] x1;
      logic [HW-1:0] y2;
      logic [HW-1:0] y1;
   } hist_type;

   // ---------------- coefficient registers ----------------
   logic signed [COEF_BITS-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_B0_RESET;
         coef_b1_ff <= COEF_B1_RESET;
         coef_b2_ff <= COEF_B2_RESET;
         coef_a1_ff <= COEF_A1_RESET;
         coef_a2_ff <= COEF_A2_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEF_B0: coef_b0_ff <= csr_data;
            CSR_COEF_B1: coef_b1_ff <= csr_data;
            CSR_COEF_B2: coef_b2_ff <= csr_data;
            CSR_COEF_A1: coef_a1_ff <= csr_data;
            CSR_COEF_A2: coef_a2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input decode and interlock ----------------
   logic [CHAN_BITS-1:0] req_chan;
   logic [SB-1:0]        req_sample;
   logic [AW-1:0]        req_addr;
   logic                 chan_ok;
   logic                 hazard;
   logic                 stall;
   logic                 advance;
   logic                 req_take;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [AW-1:0] s1_chan_ff, s2_chan_ff, s3_chan_ff, s4_chan_ff;

   logic rsp_valid_ff, rsp_valid_in;

   assign req_chan   = req_tdata[CHAN_BITS-1:0];
   assign req_sample = req_tdata[CHAN_BITS +: SB];
   assign req_addr   = AW'(req_chan);
   assign chan_ok    = int'(req_chan) < NUM_CHANNELS;

   // hold a channel back while its history is still in flight
   assign hazard = chan_ok &&
                   ((s1_valid_ff && (s1_chan_ff == req_addr)) ||
                    (s2_valid_ff && (s2_chan_ff == req_addr)) ||
                    (s3_valid_ff && (s3_chan_ff == req_addr)) ||
                    (s4_valid_ff && (s4_chan_ff == req_addr)));

   assign stall      = s4_valid_ff && rsp_valid_ff && !rsp_tready;
   assign advance    = !stall;
   assign req_tready = !stall && !hazard;
   assign req_take   = req_tvalid && req_tready;

   // ---------------- history memory ----------------
   logic                    ram_rd_en, ram_wr_en;
   hist_type                ram_rd_data, ram_wr_data;
   logic [NUM_CHANNELS-1:0] hist_valid_ff;
   logic                    s1_hist_ok_ff;

   assign ram_rd_en = req_take && chan_ok;
   assign ram_wr_en = s4_valid_ff && advance;

   mbl_ram #(
      .WIDTH ($bits(hist_type)),
      .DEPTH (NUM_CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s4_chan_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // a channel never written since reset reads as zero history
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
      end else if (ram_wr_en) begin
         hist_valid_ff[s4_chan_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         s1_hist_ok_ff <= hist_valid_ff[req_addr];
      end
   end

   // ---------------- pipeline valids ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_take && chan_ok;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: multiply ----------------
   logic [SB-1:0] s1_sample_ff;
   hist_type      s1_hist;

   logic signed [PFF_W-1:0] s2_pb0_in, s2_pb1_in, s2_pb2_in;
   logic signed [PHI_W-1:0] s2_a1hi_in, s2_a2hi_in;
   logic signed [PLO_W-1:0] s2_a1lo_in, s2_a2lo_in;

   assign s1_hist = s1_hist_ok_ff ? ram_rd_data : '0;

   always_comb begin
      s2_pb0_in  = coef_b0_ff * $signed({1'b0, s1_sample_ff});
      s2_pb1_in  = coef_b1_ff * $signed({1'b0, s1_hist.x1});
      s2_pb2_in  = coef_b2_ff * $signed({1'b0, s1_hist.x2});
      s2_a1hi_in = coef_a1_ff * $signed(s1_hist.y1[HW-1:LO_BITS]);
      s2_a1lo_in = coef_a1_ff * $signed({1'b0, s1_hist.y1[LO_BITS-1:0]});
      s2_a2hi_in = coef_a2_ff * $signed(s1_hist.y2[HW-1:LO_BITS]);
      s2_a2lo_in = coef_a2_ff * $signed({1'b0, s1_hist.y2[LO_BITS-1:0]});
   end

   logic signed [PFF_W-1:0] s2_pb0_ff, s2_pb1_ff, s2_pb2_ff;
   logic signed [PHI_W-1:0] s2_a1hi_ff, s2_a2hi_ff;
   logic signed [PLO_W-1:0] s2_a1lo_ff, s2_a2lo_ff;
   logic [SB-1:0]           s2_x_ff, s2_x1_ff, s3_x_ff, s3_x1_ff, s4_x_ff, s4_x1_ff;
   logic [HW-1:0]           s2_y1_ff, s3_y1_ff, s4_y1_ff;

   // ---------------- stage 2: sum feedforward, rebuild feedback products ----------------
   logic signed [FF_W-1:0]  ff_sum;
   logic signed [FB_W-1:0]  fb1_full, fb2_full;
   logic signed [FFS_W-1:0] s3_ff_in;
   logic signed [FB_W-1:0]  s3_fb1_in, s3_fb2_in;

   always_comb begin
      ff_sum    = FF_W'(s2_pb0_ff) + FF_W'(s2_pb1_ff) + FF_W'(s2_pb2_ff);
      s3_ff_in  = (FFS_W'(ff_sum) <<< FF_LSH) >>> FF_RSH;
      fb1_full  = (FB_W'(s2_a1hi_ff) <<< LO_BITS) + FB_W'(s2_a1lo_ff);
      fb2_full  = (FB_W'(s2_a2hi_ff) <<< LO_BITS) + FB_W'(s2_a2lo_ff);
      s3_fb1_in = fb1_full >>> COEF_FRAC_BITS;
      s3_fb2_in = fb2_full >>> COEF_FRAC_BITS;
   end

   logic signed [FFS_W-1:0] s3_ff_ff;
   logic signed [FB_W-1:0]  s3_fb1_ff, s3_fb2_ff;

   // ---------------- stage 3: combine and clamp to history range ----------------
   logic signed [SUM_W-1:0] y_sum;
   logic [HW-1:0]           s4_y_in;

   always_comb begin
      y_sum = SUM_W'(s3_ff_ff) - SUM_W'(s3_fb1_ff) - SUM_W'(s3_fb2_ff);
      if ((&y_sum[SUM_W-1:HW-1]) || !(|y_sum[SUM_W-1:HW-1])) begin
         s4_y_in = y_sum[HW-1:0];
      end else if (y_sum[SUM_W-1]) begin
         s4_y_in = {1'b1, {(HW-1){1'b0}}};
      end else begin
         s4_y_in = {1'b0, {(HW-1){1'b1}}};
      end
   end

   logic [HW-1:0] s4_y_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_chan_ff   <= req_addr;
         s1_sample_ff <= req_sample;

         s2_chan_ff <= s1_chan_ff;
         s2_x_ff    <= s1_sample_ff;
         s2_x1_ff   <= s1_hist.x1;
         s2_y1_ff   <= s1_hist.y1;
         s2_pb0_ff  <= s2_pb0_in;
         s2_pb1_ff  <= s2_pb1_in;
         s2_pb2_ff  <= s2_pb2_in;
         s2_a1hi_ff <= s2_a1hi_in;
         s2_a1lo_ff <= s2_a1lo_in;
         s2_a2hi_ff <= s2_a2hi_in;
         s2_a2lo_ff <= s2_a2lo_in;

         s3_chan_ff <= s2_chan_ff;
         s3_x_ff    <= s2_x_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_ff_ff   <= s3_ff_in;
         s3_fb1_ff  <= s3_fb1_in;
         s3_fb2_ff  <= s3_fb2_in;

         s4_chan_ff <= s3_chan_ff;
         s4_x_ff    <= s3_x_ff;
         s4_x1_ff   <= s3_x1_ff;
         s4_y1_ff   <= s3_y1_ff;
         s4_y_ff    <= s4_y_in;
      end
   end

   // ---------------- stage 4: write back history, form result ----------------
   logic [HW-2:0]        y_int;
   logic [FILT_BITS-1:0] filt;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   always_comb begin
      ram_wr_data.y1 = s4_y_ff;
      ram_wr_data.y2 = s4_y1_ff;
      ram_wr_data.x1 = s4_x_ff;
      ram_wr_data.x2 = s4_x1_ff;
   end

   always_comb begin
      y_int = s4_y_ff[HW-2:0] >> HIST_FRAC_BITS;
      if (s4_y_ff[HW-1]) begin
         filt = '0;
      end else if (y_int > (HW-1)'(FILT_MAX)) begin
         filt = FILT_MAX;
      end else begin
         filt = y_int[FILT_BITS-1:0];
      end
      rsp_tdata_in = RSP_W'({filt, CHAN_BITS'(s4_chan_ff)});
   end

   // ---------------- output register ----------------
   always_comb begin
      if (ram_wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- assertions ----------------
   a_no_dup_early: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_chan_ff != s2_chan_ff))
      else $error("two items of one channel in stages one and two");

   a_no_dup_late: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s4_valid_ff) |-> (s1_chan_ff != s4_chan_ff))
      else $error("history read while the same channel awaits write-back");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !stall) |=> rsp_tvalid)
      else $error("item left the last stage without a result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      stall |-> !req_tready)
      else $error("input taken while the pipe is stalled");

endmodule

/* sim/multichannel_biquad_lowpass_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the six-channel biquad low-pass filter: a directed table,
// then random samples under several coefficient sets, scored against a local
// fixed-point filter or a typed-in value. Depends on mbl_pkg and multichannel_biquad_lowpass.
module multichannel_biquad_lowpass_tb;
   import mbl_pkg::*;

   localparam int REQ_BITS     = ((CHAN_BITS + SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int RSP_BITS     = ((CHAN_BITS + FILT_BITS + 7) / 8) * 8;
   localparam int WIDE         = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 75;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   localparam logic signed [WIDE-1:0] HIST_HI = (80'sd1 <<< (HIST_BITS - 1)) - 80'sd1;
   localparam logic signed [WIDE-1:0] HIST_LO = -(80'sd1 <<< (HIST_BITS - 1));
   localparam logic [COEF_BITS-1:0] GAIN_MAX = 32'h7FFF_FFFF;
   localparam logic [COEF_BITS-1:0] GAIN_MIN = 32'h8000_0000;
   localparam logic [COEF_BITS-1:0] GAIN_ONE = 32'h1000_0000;
   localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_TOP = '1;

   typedef struct packed {
      logic [CHAN_BITS-1:0] chan;
      logic [FILT_BITS-1:0] filt;
   } filt_result_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]       chan;
      logic [SAMPLE_BITS_DEF-1:0] sample;
      logic                       typed;
      logic [FILT_BITS-1:0]       filt;
   } stim_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE
   } ready_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // chan [2:0], sample [14:3], zero fill
   logic [REQ_BITS-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // out_chan [2:0], filtered [18:3], zero fill
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0] csr_data = '0;

   // typed-in expectation riding along with the item on the bus
   logic                 typed_check = 1'b0;
   logic [FILT_BITS-1:0] typed_filt = '0;

   logic signed [COEF_BITS-1:0] gain_reg [5];
   logic [SAMPLE_BITS_DEF-1:0]  x_one [NUM_CHANNELS_DEF];
   logic [SAMPLE_BITS_DEF-1:0]  x_two [NUM_CHANNELS_DEF];
   logic signed [HIST_BITS-1:0] y_one [NUM_CHANNELS_DEF];
   logic signed [HIST_BITS-1:0] y_two [NUM_CHANNELS_DEF];

   filt_result_type pending_results [$];
   int           error_count = 0;
   int           burst_left = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   logic [15:0]  ready_pattern = '1;
   int           ready_span = 0;

   stim_row_type directed_rows [0:21] = '{
      '{3'd0, 12'd0, 1'b1, 16'd0},
      '{3'd1, 12'd0, 1'b1, 16'd0},
      '{3'd2, 12'd0, 1'b1, 16'd0},
      '{3'd3, 12'd0, 1'b1, 16'd0},
      '{3'd4, 12'd0, 1'b1, 16'd0},
      '{3'd5, 12'd0, 1'b1, 16'd0},
      '{3'd6, 12'd4095, 1'b0, 16'd0},     // channel out of range: dropped
      '{3'd7, 12'd4095, 1'b0, 16'd0},
      '{3'd0, 12'd4095, 1'b1, 16'd0},     // full step from rest stays below one
      '{3'd0, 12'd4095, 1'b0, 16'd0},
      '{3'd0, 12'd4095, 1'b0, 16'd0},
      '{3'd1, 12'd1, 1'b0, 16'd0},
      '{3'd2, 12'd2048, 1'b0, 16'd0},
      '{3'd3, 12'h555, 1'b0, 16'd0},
      '{3'd3, 12'hAAA, 1'b0, 16'd0},
      '{3'd4, 12'd4095, 1'b0, 16'd0},
      '{3'd5, 12'd4095, 1'b0, 16'd0},
      '{3'd6, 12'd0, 1'b0, 16'd0},
      '{3'd7, 12'h555, 1'b0, 16'd0},
      '{3'd5, 12'd0, 1'b0, 16'd0},
      '{3'd0, 12'd0, 1'b0, 16'd0},
      '{3'd2, 12'd4095, 1'b0, 16'd0}
   };

   multichannel_biquad_lowpass DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // One filter step for one channel; advances that channel's history.
   function automatic logic [FILT_BITS-1:0] lowpass_predict(
      input logic [CHAN_BITS-1:0] ch, input logic [SAMPLE_BITS_DEF-1:0] x);
      logic signed [WIDE-1:0] g0, g1, g2, ga1, ga2;
      logic signed [WIDE-1:0] xs, x1s, x2s, y1s, y2s;
      logic signed [WIDE-1:0] feed, acc;
      g0  = gain_reg[CSR_COEF_B0];
      g1  = gain_reg[CSR_COEF_B1];
      g2  = gain_reg[CSR_COEF_B2];
      ga1 = gain_reg[CSR_COEF_A1];
      ga2 = gain_reg[CSR_COEF_A2];
      xs  = x;
      x1s = x_one[ch];
      x2s = x_two[ch];
      y1s = y_one[ch];
      y2s = y_two[ch];
      feed = g0 * xs + g1 * x1s + g2 * x2s;
      if (HIST_FRAC_BITS_DEF >= COEF_FRAC_BITS_DEF) begin
         feed = feed <<< (HIST_FRAC_BITS_DEF - COEF_FRAC_BITS_DEF);
      end else begin
         feed = feed >>> (COEF_FRAC_BITS_DEF - HIST_FRAC_BITS_DEF);
      end
      // arithmetic shift of the exact product rounds toward minus infinity
      acc = feed - ((ga1 * y1s) >>> COEF_FRAC_BITS_DEF)
                 - ((ga2 * y2s) >>> COEF_FRAC_BITS_DEF);
      if (acc > HIST_HI) begin
         acc = HIST_HI;
      end else if (acc < HIST_LO) begin
         acc = HIST_LO;
      end
      x_two[ch] = x_one[ch];
      x_one[ch] = x;
      y_two[ch] = y_one[ch];
      y_one[ch] = acc[HIST_BITS-1:0];
      if (acc < 0) return '0;
      if ((acc >>> HIST_FRAC_BITS_DEF) > WIDE'(FILT_MAX)) return FILT_MAX;
      return acc[HIST_FRAC_BITS_DEF +: FILT_BITS];
   endfunction

   function automatic logic [COEF_BITS-1:0] random_gain();
      if ($urandom_range(0, 1) == 0) return $urandom;
      // keep within +-1.0 so the filter often stays out of saturation
      return COEF_BITS'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
   endfunction

   // Score every handshake at the rising edge.
   always @(posedge clock) begin : scoreboard
      logic [CHAN_BITS-1:0]       in_chan;
      logic [SAMPLE_BITS_DEF-1:0] in_sample;
      filt_result_type            predicted;
      filt_result_type            want;
      filt_result_type            got;
      if (reset) begin
         gain_reg[CSR_COEF_B0] <= COEF_B0_RESET;
         gain_reg[CSR_COEF_B1] <= COEF_B1_RESET;
         gain_reg[CSR_COEF_B2] <= COEF_B2_RESET;
         gain_reg[CSR_COEF_A1] <= COEF_A1_RESET;
         gain_reg[CSR_COEF_A2] <= COEF_A2_RESET;
         for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            x_one[i] = '0;
            x_two[i] = '0;
            y_one[i] = '0;
            y_two[i] = '0;
         end
      end else begin
         if (csr_valid && csr_ready && csr_index <= CSR_COEF_A2) begin
            gain_reg[csr_index] <= csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.chan = rsp_tdata[CHAN_BITS-1:0];
            got.filt = rsp_tdata[CHAN_BITS +: FILT_BITS];
            if (pending_results.size() == 0) begin
               $error("unexpected result: out_chan %0d filtered %0d", got.chan, got.filt);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.chan !== want.chan) begin
                  $error("out_chan mismatch: expected %0d, got %0d", want.chan, got.chan);
                  error_count++;
               end
               if (got.filt !== want.filt) begin
                  $error("filtered mismatch: expected %0d, got %0d", want.filt, got.filt);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            in_chan   = req_tdata[CHAN_BITS-1:0];
            in_sample = req_tdata[CHAN_BITS +: SAMPLE_BITS_DEF];
            if (in_chan < NUM_CHANNELS_DEF) begin
               predicted.chan = in_chan;
               predicted.filt = lowpass_predict(in_chan, in_sample);
               if (typed_check) predicted.filt = typed_filt;
               pending_results.push_back(predicted);
            end
         end
      end
   end

   // Receiver backpressure: modes of random length.
   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_span    = $urandom_range(16, 96);
         ready_mode    = ready_mode_type'($urandom_range(0, 3));
         ready_pattern = 16'($urandom);
      end else begin
         ready_span--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         READY_PATTERN: begin
            rsp_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_sample(input logic [CHAN_BITS-1:0] ch,
                              input logic [SAMPLE_BITS_DEF-1:0] sample,
                              input logic typed, input logic [FILT_BITS-1:0] filt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      end
      burst_left--;
      @(negedge clock);
      req_tvalid  <= 1'b1;
      req_tdata   <= '0;
      req_tdata[CHAN_BITS-1:0] <= ch;
      req_tdata[CHAN_BITS +: SAMPLE_BITS_DEF] <= sample;
      typed_check <= typed;
      typed_filt  <= filt;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, let every result come back, then let the bench settle.
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic load_gains(input logic [COEF_BITS-1:0] b0, b1, b2, a1, a2);
      write_reg(CSR_COEF_B0, b0);
      write_reg(CSR_COEF_B1, b1);
      write_reg(CSR_COEF_B2, b2);
      write_reg(CSR_COEF_A1, a1);
      write_reg(CSR_COEF_A2, a2);
   endtask

   task automatic random_samples(input int count);
      int sent;
      int sweep_chan;
      logic [CHAN_BITS-1:0] ch;
      logic [SAMPLE_BITS_DEF-1:0] sample;
      sent = 0;
      sweep_chan = 0;
      while (sent < count) begin
         case ($urandom_range(0, 3))
            0: sample = '0;
            1: sample = SAMPLE_TOP;
            default: sample = SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_TOP));
         endcase
         if ($urandom_range(0, 19) == 0) begin
            // out-of-range channel, no result
            send_sample(CHAN_BITS'($urandom_range(NUM_CHANNELS_DEF, 2**CHAN_BITS - 1)),
                        sample, 1'b0, '0);
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               ch = CHAN_BITS'(sweep_chan);
               sweep_chan = (sweep_chan + 1) % NUM_CHANNELS_DEF;
            end else begin
               ch = CHAN_BITS'($urandom_range(0, NUM_CHANNELS_DEF - 1));
            end
            send_sample(ch, sample, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].chan, directed_rows[i].sample,
                     directed_rows[i].typed, directed_rows[i].filt);
      end
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               // unity pass-through; unused indexes must not touch any gain
               load_gains(GAIN_ONE, '0, '0, '0, '0);
               for (int i = CSR_COEF_A2 + 1; i < 2**CSR_INDEX_BITS; i++) begin
                  write_reg(CSR_INDEX_BITS'(i), $urandom);
               end
            end
            1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
            2: load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
            3: load_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, GAIN_MAX);
            RANDOM_PHASES - 1: load_gains(COEF_B0_RESET, COEF_B1_RESET, COEF_B2_RESET,
                                          COEF_A1_RESET, COEF_A2_RESET);
            default: load_gains(random_gain(), random_gain(), random_gain(),
                                random_gain(), random_gain());
         endcase
         random_samples(ITEMS_PER_PHASE);
         drain();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* multichannel_biquad_lowpass.f */
rtl/core/mbl_pkg.sv
rtl/core/mbl_ram.sv
rtl/core/multichannel_biquad_lowpass.sv
sim/multichannel_biquad_lowpass_tb.sv
